### hw/rtl/lqug_pkg.sv
// shared types and constants of the lehmer quad uuid generator
`default_nettype none

package lqug_pkg;

    localparam int HALF_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int CFG_W     = 64;
    localparam int SEED_N    = 4;
    localparam int MUL_W     = 29;
    localparam int IN_DATA_W = 136;
    localparam int OUT_DATA_W = 128;
    localparam int REG_IDX_W = 2;

    localparam logic [MUL_W-1:0]  LEHMER_MUL = 29'd279470273;
    localparam logic [HALF_W-1:0] LEHMER_MOD = 32'd4294967291;
    // 2^32 mod the modulus
    localparam logic [2:0]        LEHMER_FOLD = 3'd5;

    localparam logic [CFG_W-1:0] SEED_PAIR_LOW_RST  = 64'h0000_0002_0000_0001;
    localparam logic [CFG_W-1:0] SEED_PAIR_HIGH_RST = 64'h0000_0004_0000_0003;

    typedef enum logic [1:0] {
        OP_UUID   = 2'd0,
        OP_RAND   = 2'd1,
        OP_LESS   = 2'd2,
        OP_RELOAD = 2'd3
    } t_opcode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NONCE_LOW      = 2'd0,
        REG_NONCE_HIGH     = 2'd1,
        REG_SEED_PAIR_LOW  = 2'd2,
        REG_SEED_PAIR_HIGH = 2'd3
    } t_reg_idx;

    typedef logic [SEED_N-1:0][HALF_W-1:0] t_seed_vec;

    typedef struct packed {
        logic advance;
        logic reload;
    } t_seed_ctl;

endpackage

`default_nettype wire

### hw/rtl/lehmer_quad_uuid_generator_core.sv
// top level of the lehmer quad uuid generator
// Takes one request word per clock and returns one result word per request, in the cycle
// after acceptance, in order. The seed bank always holds the seeds of the next draw,
// computed one step ahead by four multiply-and-fold lanes, so the throughput of one word
// per cycle is set by that single lehmer step in the seed feedback loop. The output
// register takes the next word in the same cycle its result is read; while a result
// waits unread, the input is held off. Configuration writes take effect at once for the
// nonces; new seed pairs take effect at the next reload.
`default_nettype none

module lehmer_quad_uuid_generator_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // opcode [1:0], uuid_in_low [65:2], uuid_in_high [129:66], zero pad [135:130]
    input  wire logic [lqug_pkg::IN_DATA_W-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // value_low [63:0], value_high [127:64]
    output logic [lqug_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [lqug_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lqug_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import lqug_pkg::*;

    logic [CFG_W-1:0]      r_nonce_low;
    logic [CFG_W-1:0]      r_nonce_high;
    logic [CFG_W-1:0]      r_seed_pair_low;
    logic [CFG_W-1:0]      r_seed_pair_high;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic                  accept;
    t_opcode               op;
    logic [VALUE_W-1:0]    uuid_low;
    logic [VALUE_W-1:0]    uuid_high;
    t_seed_vec             seeds;
    t_seed_ctl             seed_ctl;
    logic [VALUE_W-1:0]    rnd;
    logic [VALUE_W-1:0]    rnd_high;
    logic [VALUE_W-1:0]    diff;
    logic [VALUE_W-1:0]    val_low;
    logic [VALUE_W-1:0]    val_high;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign op         = t_opcode'(i_s_tdata[1:0]);
    assign uuid_low   = i_s_tdata[65:2];
    assign uuid_high  = i_s_tdata[129:66];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce_low      <= '0;
            r_nonce_high     <= '0;
            r_seed_pair_low  <= SEED_PAIR_LOW_RST;
            r_seed_pair_high <= SEED_PAIR_HIGH_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_NONCE_LOW:      r_nonce_low      <= i_cfg_wdata;
                REG_NONCE_HIGH:     r_nonce_high     <= i_cfg_wdata;
                REG_SEED_PAIR_LOW:  r_seed_pair_low  <= i_cfg_wdata;
                REG_SEED_PAIR_HIGH: r_seed_pair_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign seed_ctl.advance = accept && (op != OP_RELOAD);
    assign seed_ctl.reload  = accept && (op == OP_RELOAD);

    lqug_seed_bank u_seed_bank (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (seed_ctl),
        .i_seed_pair_low  (r_seed_pair_low),
        .i_seed_pair_high (r_seed_pair_high),
        .o_seeds          (seeds)
    );

    always_comb begin
        rnd      = {seeds[1], seeds[0]};
        rnd_high = {seeds[3], seeds[2]};
        diff     = uuid_low - rnd;
        case (op)
            OP_UUID: begin
                val_low  = rnd ^ r_nonce_low;
                val_high = rnd_high ^ r_nonce_high;
            end
            OP_RAND: begin
                val_low  = rnd;
                val_high = '0;
            end
            OP_LESS: begin
                // borrow also taken when the random value is zero
                val_low  = diff;
                val_high = uuid_high - VALUE_W'(diff >= uuid_low);
            end
            default: begin
                val_low  = '0;
                val_high = '0;
            end
        endcase
        n_out_data = {val_high, val_low};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_reload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_RELOAD) |=> (o_m_tvalid && o_m_tdata == '0))
        else $error("reload word not zero");

    a_rand_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_RAND) |=> (o_m_tvalid && o_m_tdata[127:64] == '0))
        else $error("random word high half not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while waiting");

endmodule

`default_nettype wire

### hw/rtl/lqug_lehmer.sv
// one lehmer step: multiply by the constant, reduce modulo 2^32-5
`default_nettype none

module lqug_lehmer (
    input  wire logic [lqug_pkg::HALF_W-1:0] i_x,
    output logic      [lqug_pkg::HALF_W-1:0] o_y
);
    import lqug_pkg::*;

    localparam int PROD_W = HALF_W + MUL_W;

    logic [PROD_W-1:0]   prod;
    logic [HALF_W+1:0]   fold1;
    logic [HALF_W:0]     fold2;

    always_comb begin
        prod  = PROD_W'(i_x) * PROD_W'(LEHMER_MUL);
        // high part times 2^32 is congruent to high part times five
        fold1 = (HALF_W+2)'(prod[HALF_W-1:0])
              + ((HALF_W+2)'(prod[PROD_W-1:HALF_W]) << 2)
              + (HALF_W+2)'(prod[PROD_W-1:HALF_W]);
        fold2 = (HALF_W+1)'(fold1[HALF_W-1:0])
              + (fold1[HALF_W] ? (HALF_W+1)'(LEHMER_FOLD) : '0);
        if (fold2 >= (HALF_W+1)'(LEHMER_MOD)) begin
            o_y = HALF_W'(fold2 - (HALF_W+1)'(LEHMER_MOD));
        end else begin
            o_y = fold2[HALF_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lqug_seed_bank.sv
// seed register holding the next advanced seeds, with four lehmer lanes
`default_nettype none

module lqug_seed_bank (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lqug_pkg::t_seed_ctl        i_ctl,
    input  wire logic [lqug_pkg::CFG_W-1:0] i_seed_pair_low,
    input  wire logic [lqug_pkg::CFG_W-1:0] i_seed_pair_high,
    output lqug_pkg::t_seed_vec             o_seeds
);
    import lqug_pkg::*;

    t_seed_vec r_adv;
    t_seed_vec n_adv;
    t_seed_vec src;

    always_comb begin
        if (!i_rst_n) begin
            src = {SEED_PAIR_HIGH_RST, SEED_PAIR_LOW_RST};
        end else if (i_ctl.reload) begin
            src = {i_seed_pair_high, i_seed_pair_low};
        end else begin
            src = r_adv;
        end
    end

    // rotating step: new seed i comes from old seed i+1
    for (genvar g = 0; g < SEED_N; g++) begin : g_lane
        lqug_lehmer u_lehmer (
            .i_x (src[(g + 1) % SEED_N]),
            .o_y (n_adv[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv <= n_adv;
        end else if (i_ctl.advance || i_ctl.reload) begin
            r_adv <= n_adv;
        end
    end

    assign o_seeds = r_adv;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctl.advance && !i_ctl.reload) |=> $stable(r_adv))
        else $error("seeds changed without a request");

    a_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_adv[0] < LEHMER_MOD) && (r_adv[1] < LEHMER_MOD)
        && (r_adv[2] < LEHMER_MOD) && (r_adv[3] < LEHMER_MOD))
        else $error("seed not reduced below modulus");

    a_zero_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.advance && !i_ctl.reload && r_adv[1] == '0) |=> (r_adv[0] == '0))
        else $error("zero seed did not stay zero");

endmodule

`default_nettype wire

### bench/lehmer_quad_uuid_generator_core_test.sv
// self-checking stream testbench for the lehmer quad uuid generator core
`timescale 1ns / 1ps
`default_nettype none

module lehmer_quad_uuid_generator_core_test;
    import lqug_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PRINT_LIMIT = 40;
    localparam int unsigned RANDOM_PHASES = 7;
    localparam int unsigned PHASE_WORDS = 150;

    typedef struct packed {
        logic [5:0]         pad;
        logic [VALUE_W-1:0] uuid_high;
        logic [VALUE_W-1:0] uuid_low;
        t_opcode            opcode;
    } t_request;

    typedef struct packed {
        logic [VALUE_W-1:0] value_high;
        logic [VALUE_W-1:0] value_low;
    } t_result;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    t_reg_idx              cfg_idx = REG_NONCE_LOW;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // register copies and seed bank of the predictor
    logic [CFG_W-1:0]  nonce_low_reg = '0;
    logic [CFG_W-1:0]  nonce_high_reg = '0;
    logic [CFG_W-1:0]  pair_low_reg = SEED_PAIR_LOW_RST;
    logic [CFG_W-1:0]  pair_high_reg = SEED_PAIR_HIGH_RST;
    logic [HALF_W-1:0] seed_bank [SEED_N];

    t_request    request_q [$];
    t_result     expected_q [$];
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit          steady_flow = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned result_count = 0;
    int unsigned write_count = 0;
    int unsigned op_count [4] = '{0, 0, 0, 0};

    lehmer_quad_uuid_generator_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [HALF_W-1:0] lehmer_step(logic [HALF_W-1:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {35'd0, LEHMER_MUL};
        return HALF_W'(prod % {32'd0, LEHMER_MOD});
    endfunction

    // advances or reloads the seed bank and returns the word the block should send
    function automatic t_result predict_result(t_request req);
        t_result            res;
        logic [VALUE_W-1:0] draw;
        logic [HALF_W-1:0]  first;
        res = '0;
        if (req.opcode == OP_RELOAD) begin
            seed_bank[0] = pair_low_reg[31:0];
            seed_bank[1] = pair_low_reg[63:32];
            seed_bank[2] = pair_high_reg[31:0];
            seed_bank[3] = pair_high_reg[63:32];
        end else begin
            first = seed_bank[0];
            seed_bank[0] = lehmer_step(seed_bank[1]);
            seed_bank[1] = lehmer_step(seed_bank[2]);
            seed_bank[2] = lehmer_step(seed_bank[3]);
            seed_bank[3] = lehmer_step(first);
            draw = {seed_bank[1], seed_bank[0]};
            case (req.opcode)
                OP_UUID: begin
                    res.value_low  = draw ^ nonce_low_reg;
                    res.value_high = {seed_bank[3], seed_bank[2]} ^ nonce_high_reg;
                end
                OP_RAND: begin
                    res.value_low = draw;
                end
                default: begin
                    // borrow test also fires when the draw is zero
                    res.value_low  = req.uuid_low - draw;
                    res.value_high = req.uuid_high;
                    if (res.value_low >= req.uuid_low) begin
                        res.value_high = req.uuid_high - 64'd1;
                    end
                end
            endcase
        end
        return res;
    endfunction

    function automatic int unsigned draw_gap(bit steady);
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_field();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [HALF_W-1:0] pick_seed_half();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFFB);
        if (roll < 14) return '0;
        return $urandom;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic queue_request(t_opcode op, logic [63:0] lo, logic [63:0] hi);
        t_request req;
        req = '0;
        req.opcode    = op;
        req.uuid_low  = lo;
        req.uuid_high = hi;
        request_q.push_back(req);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_NONCE_LOW:     nonce_low_reg = value;
            REG_NONCE_HIGH:    nonce_high_reg = value;
            REG_SEED_PAIR_LOW: pair_low_reg = value;
            default:           pair_high_reg = value;
        endcase
        write_count++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge clk);
        end while (request_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
            seed_bank[0] = pair_low_reg[31:0];
            seed_bank[1] = pair_low_reg[63:32];
            seed_bank[2] = pair_high_reg[31:0];
            seed_bank[3] = pair_high_reg[63:32];
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_result(t_request'(s_tdata)));
                op_count[s_tdata[1:0]]++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    s_tdata  <= request_q.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= draw_gap(steady_flow);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata);
                result_count++;
                if (expected_q.size() == 0) begin
                    note_mismatch("unexpected word, value_low", got.value_low, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.value_low !== want.value_low) begin
                        note_mismatch("value_low", got.value_low, want.value_low);
                    end
                    if (got.value_high !== want.value_high) begin
                        note_mismatch("value_high", got.value_high, want.value_high);
                    end
                end
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(3) == 0) begin
                    recv_gap <= draw_gap(steady_flow);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped at cycle limit with %0d words outstanding", expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned roll;
        t_opcode     op;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset seeds, zero nonces
        queue_request(OP_RELOAD, '0, '0);
        queue_request(OP_UUID, '0, '0);
        queue_request(OP_RAND, '1, '1);
        queue_request(OP_LESS, '0, '0);
        queue_request(OP_LESS, '1, '1);
        queue_request(OP_LESS, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(OP_LESS, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_request(OP_LESS, '0, '1);
        queue_request(OP_UUID, '1, '0);
        wait_drained();

        // seeds at and above the modulus
        write_reg(REG_NONCE_LOW, '1);
        write_reg(REG_NONCE_HIGH, 64'h5555_5555_5555_5555);
        write_reg(REG_SEED_PAIR_LOW, {32'hFFFF_FFFB, 32'hFFFF_FFFF});
        write_reg(REG_SEED_PAIR_HIGH, {32'hFFFF_FFFC, 32'hFFFF_FFFD});
        queue_request(OP_UUID, '0, '0);
        queue_request(OP_RELOAD, '1, '1);
        queue_request(OP_UUID, '0, '0);
        queue_request(OP_RAND, '0, '0);
        queue_request(OP_LESS, 64'd1, '0);
        queue_request(OP_UUID, '0, '0);
        wait_drained();

        // all-zero seeds stay zero, so every subtraction borrows
        write_reg(REG_SEED_PAIR_LOW, '0);
        write_reg(REG_SEED_PAIR_HIGH, '0);
        write_reg(REG_NONCE_LOW, '0);
        write_reg(REG_NONCE_HIGH, '1);
        queue_request(OP_RELOAD, '0, '0);
        queue_request(OP_LESS, '0, '0);
        queue_request(OP_LESS, 64'd5, 64'd7);
        queue_request(OP_UUID, '0, '0);
        queue_request(OP_RAND, '0, '0);
        queue_request(OP_LESS, '1, '0);
        wait_drained();

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady_flow = (phase % 3 == 2);
            write_reg(REG_NONCE_LOW, pick_field());
            write_reg(REG_NONCE_HIGH, pick_field());
            write_reg(REG_SEED_PAIR_LOW, {pick_seed_half(), pick_seed_half()});
            write_reg(REG_SEED_PAIR_HIGH, {pick_seed_half(), pick_seed_half()});
            queue_request(OP_RELOAD, pick_field(), pick_field());
            for (int unsigned n = 1; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(99);
                if (roll < 8) op = OP_RELOAD;
                else op = t_opcode'($urandom_range(2));
                queue_request(op, pick_field(), pick_field());
            end
            wait_drained();
        end
        steady_flow = 1'b0;

        repeat (10) @(posedge clk);
        $display("covered %0d uuid, %0d random, %0d less and %0d reload requests",
                 op_count[OP_UUID], op_count[OP_RAND], op_count[OP_LESS], op_count[OP_RELOAD]);
        $display("checked %0d result words across %0d register writes, %0d mismatches",
                 result_count, write_count, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
